@@ hdl/websocket_frame_header_parser_assert.svh @@
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH

// property checked outside reset
`define WSFHP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("websocket header parser check failed");

// property checked in every cycle, reset included
`define WSFHP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("websocket header parser check failed");

`endif

@@ hdl/wsfhp_pkg.sv @@
package wsfhp_pkg;

   localparam logic [7:0] RSV_MASK    = 8'h70;
   localparam logic [7:0] OP_RSV_BIT  = 8'h04;
   localparam logic [7:0] CTRL_MASK   = 8'h0C;
   localparam logic [7:0] CTRL_VALUE  = 8'h08;
   localparam logic [7:0] FIN_BIT     = 8'h80;
   localparam logic [6:0] LEN_EXT16   = 7'h7E;
   localparam logic [6:0] LEN_EXT64   = 7'h7F;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RSV_BITS = 2'd1;
   localparam logic [1:0] ST_BAD_OP   = 2'd2;
   localparam logic [1:0] ST_CTRL_FIN = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic        fin_bit;
      logic [3:0]  opcode;
      logic        masked;
      logic [31:0] mask_key;
      logic [63:0] payload_length;
      logic [3:0]  header_length;
   } result_type;

endpackage

@@ hdl/wsfhp_req_if.sv @@
interface wsfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       first_byte;

   modport source (output valid, output header_byte, output first_byte, input ready);
   modport sink   (input valid, input header_byte, input first_byte, output ready);
endinterface

@@ hdl/wsfhp_rsp_if.sv @@
interface wsfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        fin_bit;
   logic [3:0]  opcode;
   logic        masked;
   logic [31:0] mask_key;
   logic [63:0] payload_length;
   logic [3:0]  header_length;

   modport source (output valid, output status, output fin_bit, output opcode,
                   output masked, output mask_key, output payload_length,
                   output header_length, input ready);
   modport sink   (input valid, input status, input fin_bit, input opcode,
                   input masked, input mask_key, input payload_length,
                   input header_length, output ready);
endinterface

@@ hdl/wsfhp_core.sv @@
`include "websocket_frame_header_parser_assert.svh"

module wsfhp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             header_byte,
   input  logic                   first_byte,
   output logic                   res_valid,
   output wsfhp_pkg::result_type  res
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LEN7   = 3'd1;
   localparam logic [2:0] PH_EXTLEN = 3'd2;
   localparam logic [2:0] PH_KEY    = 3'd3;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [3:0]  count_ff, count_in;
   logic        finish;
   logic [1:0]  err_code;
   logic        err;
   logic [6:0]  code;
   logic [3:0]  left_dec;

   assign code     = header_byte[6:0];
   assign left_dec = left_ff - 4'd1;

   always_comb begin
      err_code = wsfhp_pkg::ST_OK;
      if ((header_byte & wsfhp_pkg::RSV_MASK) != 8'h00) begin
         err_code = wsfhp_pkg::ST_RSV_BITS;
      end else if ((header_byte & wsfhp_pkg::OP_RSV_BIT) != 8'h00) begin
         err_code = wsfhp_pkg::ST_BAD_OP;
      end else if ((header_byte & wsfhp_pkg::FIN_BIT) == 8'h00 &&
                   (header_byte & wsfhp_pkg::CTRL_MASK) == wsfhp_pkg::CTRL_VALUE) begin
         err_code = wsfhp_pkg::ST_CTRL_FIN;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      finish    = 1'b0;
      err       = 1'b0;
      if (first_byte) begin
         phase_in  = PH_IDLE;
         left_in   = 4'd0;
         len_in    = 64'd0;
         key_in    = 32'd0;
         masked_in = 1'b0;
         count_in  = 4'd0;
         if (err_code != wsfhp_pkg::ST_OK) begin
            err = 1'b1;
         end else begin
            fin_in    = header_byte[7];
            opcode_in = header_byte[3:0];
            count_in  = 4'd1;
            phase_in  = PH_LEN7;
         end
      end else begin
         case (phase_ff)
            PH_LEN7: begin
               count_in  = 4'd2;
               masked_in = header_byte[7];
               len_in    = 64'd0;
               key_in    = 32'd0;
               if (code == wsfhp_pkg::LEN_EXT64) begin
                  phase_in = PH_EXTLEN;
                  left_in  = 4'd8;
               end else if (code == wsfhp_pkg::LEN_EXT16) begin
                  phase_in = PH_EXTLEN;
                  left_in  = 4'd2;
               end else begin
                  len_in = {57'd0, code};
                  if (header_byte[7]) begin
                     phase_in = PH_KEY;
                     left_in  = 4'd4;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               len_in   = {len_ff[55:0], header_byte};
               count_in = count_ff + 4'd1;
               left_in  = left_dec;
               if (left_dec == 4'd0) begin
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                     left_in  = 4'd4;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               key_in   = {key_ff[23:0], header_byte};
               count_in = count_ff + 4'd1;
               left_in  = left_dec;
               if (left_dec == 4'd0) begin
                  finish = 1'b1;
               end
            end
            default: begin
               // stray byte outside a header is dropped
            end
         endcase
         if (finish) begin
            phase_in = PH_IDLE;
            left_in  = 4'd0;
         end
      end
   end

   always_comb begin
      res_valid = step_en && (finish || err);
      if (err) begin
         res = '0;
         res.status = err_code;
      end else begin
         res.status         = wsfhp_pkg::ST_OK;
         res.fin_bit        = fin_in;
         res.opcode         = opcode_in;
         res.masked         = masked_in;
         res.mask_key       = masked_in ? key_in : 32'd0;
         res.payload_length = len_in;
         res.header_length  = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         left_ff   <= 4'd0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         len_ff    <= 64'd0;
         key_ff    <= 32'd0;
         count_ff  <= 4'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         len_ff    <= len_in;
         key_ff    <= key_in;
         count_ff  <= count_in;
      end
   end

   `WSFHP_ASSERT(a_idle_no_left, clock, reset, (phase_ff == PH_IDLE) |-> (left_ff == 4'd0))
   `WSFHP_ASSERT(a_key_needs_mask, clock, reset, (phase_ff == PH_KEY) |-> masked_ff)
   `WSFHP_ASSERT(a_ext_has_left, clock, reset, (phase_ff == PH_EXTLEN) |-> (left_ff != 4'd0))

endmodule

@@ hdl/websocket_frame_header_parser.sv @@
// a request is registered, then parsed; its result enters the output register once that register is free
// throughput: one header byte per cycle while the result output is not stalled
// while a result waits on the output register, one more request enters the input register,
// then ready drops until the result is taken
// reset is synchronous and active high; it clears the parser state and both valid flags
`include "websocket_frame_header_parser_assert.svh"

module websocket_frame_header_parser (
   input  logic         clock,
   input  logic         reset,
   wsfhp_req_if.sink    req_ch,
   wsfhp_rsp_if.source  rsp_ch
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_first_ff;
   logic                  out_valid_ff, out_valid_in;
   wsfhp_pkg::result_type out_res_ff;
   logic                  out_free;
   logic                  step_en;
   logic                  res_valid;
   wsfhp_pkg::result_type res;
   logic                  out_err;
   logic                  out_ok;
   logic                  err_fields_zero;
   logic                  in_stall;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step_en      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign in_valid_in  = req_ch.valid || (in_valid_ff && !out_free);
   assign out_valid_in = out_free ? res_valid : out_valid_ff;

   wsfhp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .header_byte (in_byte_ff),
      .first_byte  (in_first_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff  <= req_ch.header_byte;
         in_first_ff <= req_ch.first_byte;
      end
      if (out_free && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_res_ff.status;
   assign rsp_ch.fin_bit        = out_res_ff.fin_bit;
   assign rsp_ch.opcode         = out_res_ff.opcode;
   assign rsp_ch.masked         = out_res_ff.masked;
   assign rsp_ch.mask_key       = out_res_ff.mask_key;
   assign rsp_ch.payload_length = out_res_ff.payload_length;
   assign rsp_ch.header_length  = out_res_ff.header_length;

   assign out_err         = out_valid_ff && (out_res_ff.status != wsfhp_pkg::ST_OK);
   assign out_ok          = out_valid_ff && (out_res_ff.status == wsfhp_pkg::ST_OK);
   assign err_fields_zero = (out_res_ff.header_length == 4'd0) &&
                            (out_res_ff.payload_length == 64'd0);
   assign in_stall        = in_valid_ff && !out_free;

   `WSFHP_ASSERT(a_err_zero_fields, clock, reset, out_err |-> err_fields_zero)
   `WSFHP_ASSERT(a_ok_min_header, clock, reset, out_ok |-> (out_res_ff.header_length >= 4'd2))
   `WSFHP_ASSERT(a_in_held_on_stall, clock, reset, in_stall |=> in_valid_ff && $stable(in_byte_ff))
   `WSFHP_ASSERT_ALWAYS(a_reset_clears_out, clock, reset |=> !out_valid_ff)

endmodule
